@@ rtl/tsce_pkg.sv @@
// ----------------------------------------------------------------------------
// tsce_pkg: text screen character engine shared definitions
// Screen geometry, field types, command and control codes, register map
// and the configuration bundle passed from the register block to the core.
// ----------------------------------------------------------------------------
package tsce_pkg;

   localparam int MAX_COLUMNS = 40;
   localparam int MAX_ROWS    = 24;
   localparam int TOTAL_CELLS = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W      = $clog2(TOTAL_CELLS);
   localparam int CNT_W       = $clog2(TOTAL_CELLS + 1);

   typedef logic [1:0]        cmd_type;
   typedef logic [7:0]        char_type;
   typedef logic [5:0]        col_type;
   typedef logic [4:0]        row_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;

   localparam cmd_type CMD_PUT   = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   localparam char_type CH_ESCAPE     = 8'h1B;
   localparam char_type CH_UP         = 8'h1C;
   localparam char_type CH_DOWN       = 8'h1D;
   localparam char_type CH_LEFT       = 8'h1E;
   localparam char_type CH_RIGHT      = 8'h1F;
   localparam char_type CH_CLEAR      = 8'h7D;
   localparam char_type CH_BACKSPACE  = 8'h7E;
   localparam char_type CH_EOL        = 8'h9B;
   localparam char_type CH_DEL_LINE   = 8'h9C;
   localparam char_type CH_INS_LINE   = 8'h9D;
   localparam char_type CH_BELL       = 8'hFD;
   localparam char_type CH_DEL_CHAR   = 8'hFE;
   localparam char_type CH_INS_CHAR   = 8'hFF;
   localparam char_type CH_BLANK      = 8'h20;

   localparam col_type MARGIN_LIMIT = 6'd39;

   localparam col_type WIDTH_RESET    = 6'd40;
   localparam row_type HEIGHT_RESET   = 5'd24;
   localparam col_type LEFT_RESET     = 6'd2;
   localparam col_type RIGHT_RESET    = 6'd39;

   typedef enum logic [2:0] {
      REG_SCREEN_WIDTH,
      REG_SCREEN_HEIGHT,
      REG_LEFT_MARGIN,
      REG_RIGHT_MARGIN,
      REG_DISPLAY_CONTROLS
   } reg_index_type;

   typedef struct packed {
      col_type screen_width;
      row_type screen_height;
      col_type left_margin;
      col_type right_margin;
      logic    display_controls;
   } cfg_type;

endpackage

@@ rtl/tsce_if.sv @@
// ----------------------------------------------------------------------------
// tsce channels: request and response handshake interfaces
// Each channel carries valid, ready and one word of payload.
// ----------------------------------------------------------------------------
interface tsce_req_if;
   logic               valid;
   logic               ready;
   tsce_pkg::cmd_type  command;
   tsce_pkg::char_type char_code;
   tsce_pkg::col_type  read_column;
   tsce_pkg::row_type  read_row;

   modport source (output valid, output command, output char_code,
                   output read_column, output read_row, input ready);
   modport sink   (input valid, input command, input char_code,
                   input read_column, input read_row, output ready);
endinterface

interface tsce_rsp_if;
   logic               valid;
   logic               ready;
   tsce_pkg::col_type  cursor_column;
   tsce_pkg::row_type  cursor_row;
   logic               bell;
   logic               escape_pending;
   tsce_pkg::char_type cell_value;

   modport source (output valid, output cursor_column, output cursor_row,
                   output bell, output escape_pending, output cell_value,
                   input ready);
   modport sink   (input valid, input cursor_column, input cursor_row,
                   input bell, input escape_pending, input cell_value,
                   output ready);
endinterface

@@ rtl/text_screen_character_engine.sv @@
// A cell read passes through a read wait state before its response word. Row and
// character moves copy the store cell by cell and then blank the vacated row or
// cell; clears sweep all 960 cells.
// Reset: synchronous; a blanking pass of all 960 store cells runs after reset
// with req_bus.ready low, while register writes are taken as usual.
// ----------------------------------------------------------------------------
// text_screen_character_engine: text mode screen editor top level
// Register block and store sequencer joined to the request and response
// channels.
// ----------------------------------------------------------------------------
module text_screen_character_engine (
   input  logic        clock,
   input  logic        reset,
   tsce_req_if.sink    req_bus,
   tsce_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   tsce_pkg::cfg_type cfg;

   tsce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tsce_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ rtl/tsce_csr.sv @@
// ----------------------------------------------------------------------------
// tsce_csr: configuration registers
// APB-style write and read of screen geometry, margins and raw mode.
// ----------------------------------------------------------------------------
module tsce_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output tsce_pkg::cfg_type   cfg
);

   tsce_pkg::col_type       width_ff;
   tsce_pkg::row_type       height_ff;
   tsce_pkg::col_type       left_ff;
   tsce_pkg::col_type       right_ff;
   logic                    display_ff;
   logic                    write_strobe;
   tsce_pkg::reg_index_type index;

   assign pready       = 1'b1;
   assign write_strobe = psel && penable && pwrite;
   assign index        = tsce_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= tsce_pkg::WIDTH_RESET;
         height_ff  <= tsce_pkg::HEIGHT_RESET;
         left_ff    <= tsce_pkg::LEFT_RESET;
         right_ff   <= tsce_pkg::RIGHT_RESET;
         display_ff <= 1'b0;
      end else if (write_strobe) begin
         case (index)
            tsce_pkg::REG_SCREEN_WIDTH:     width_ff   <= pwdata[5:0];
            tsce_pkg::REG_SCREEN_HEIGHT:    height_ff  <= pwdata[4:0];
            tsce_pkg::REG_LEFT_MARGIN:      left_ff    <= pwdata[5:0];
            tsce_pkg::REG_RIGHT_MARGIN:     right_ff   <= pwdata[5:0];
            tsce_pkg::REG_DISPLAY_CONTROLS: display_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         tsce_pkg::REG_SCREEN_WIDTH:     prdata = {26'd0, width_ff};
         tsce_pkg::REG_SCREEN_HEIGHT:    prdata = {27'd0, height_ff};
         tsce_pkg::REG_LEFT_MARGIN:      prdata = {26'd0, left_ff};
         tsce_pkg::REG_RIGHT_MARGIN:     prdata = {26'd0, right_ff};
         tsce_pkg::REG_DISPLAY_CONTROLS: prdata = {31'd0, display_ff};
         default:                        prdata = 32'd0;
      endcase
   end

   assign cfg.screen_width     = width_ff;
   assign cfg.screen_height    = height_ff;
   assign cfg.left_margin      = left_ff;
   assign cfg.right_margin     = right_ff;
   assign cfg.display_controls = display_ff;

endmodule

@@ rtl/tsce_engine.sv @@
// ----------------------------------------------------------------------------
// tsce_engine: screen store and command sequencer
// A small sequencer decodes each word and drives one store port pair:
// single cell writes and reads, cell by cell row and character moves, and fill sweeps.
// ----------------------------------------------------------------------------
module tsce_engine (
   input  logic              clock,
   input  logic              reset,
   input  tsce_pkg::cfg_type cfg,
   tsce_req_if.sink          req_bus,
   tsce_rsp_if.source        rsp_bus
);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_START,
      ST_DISPATCH,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_FILL,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   function automatic tsce_pkg::addr_type row_base(input tsce_pkg::row_type row);
      return tsce_pkg::addr_type'(row) * tsce_pkg::addr_type'(tsce_pkg::MAX_COLUMNS);
   endfunction

   // screen store
   tsce_pkg::char_type mem [tsce_pkg::TOTAL_CELLS];
   tsce_pkg::char_type rdata_ff;
   logic               mem_we;
   tsce_pkg::addr_type mem_waddr;
   tsce_pkg::char_type mem_wdata;
   tsce_pkg::addr_type mem_raddr;

   state_type           state_ff, state_in;
   tsce_pkg::cmd_type   cmd_ff, cmd_in;
   tsce_pkg::char_type  char_ff, char_in;
   tsce_pkg::col_type   rcol_ff, rcol_in;
   tsce_pkg::row_type   rrow_ff, rrow_in;
   tsce_pkg::col_type   wm1_ff, wm1_in;
   tsce_pkg::row_type   hm1_ff, hm1_in;
   tsce_pkg::col_type   lm_ff, lm_in;
   tsce_pkg::col_type   rm_ff, rm_in;
   logic                disp_ff, disp_in;
   tsce_pkg::col_type   col_ff, col_in;
   tsce_pkg::row_type   line_ff, line_in;
   logic                esc_ff, esc_in;
   logic                bell_ff, bell_in;
   tsce_pkg::char_type  cell_ff, cell_in;
   tsce_pkg::addr_type  dst_ff, dst_in;
   tsce_pkg::count_type copy_cnt_ff, copy_cnt_in;
   logic                row_step_ff, row_step_in;
   logic                up_ff, up_in;
   tsce_pkg::addr_type  fill_addr_ff, fill_addr_in;
   tsce_pkg::count_type fill_cnt_ff, fill_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tsce_pkg::col_type   out_col_ff, out_col_in;
   tsce_pkg::row_type   out_row_ff, out_row_in;
   logic                out_bell_ff, out_bell_in;
   logic                out_esc_ff, out_esc_in;
   tsce_pkg::char_type  out_cell_ff, out_cell_in;

   // effective geometry from the registers
   tsce_pkg::col_type w_eff, wm1_eff, lm0, rm0, rm1, rm2, lm_eff, rm_eff;
   tsce_pkg::row_type h_eff, hm1_eff;

   always_comb begin
      if (cfg.screen_width == '0) begin
         w_eff = tsce_pkg::col_type'(1);
      end else if (cfg.screen_width > tsce_pkg::col_type'(tsce_pkg::MAX_COLUMNS)) begin
         w_eff = tsce_pkg::col_type'(tsce_pkg::MAX_COLUMNS);
      end else begin
         w_eff = cfg.screen_width;
      end
      if (cfg.screen_height == '0) begin
         h_eff = tsce_pkg::row_type'(1);
      end else if (cfg.screen_height > tsce_pkg::row_type'(tsce_pkg::MAX_ROWS)) begin
         h_eff = tsce_pkg::row_type'(tsce_pkg::MAX_ROWS);
      end else begin
         h_eff = cfg.screen_height;
      end
      wm1_eff = w_eff - tsce_pkg::col_type'(1);
      hm1_eff = h_eff - tsce_pkg::row_type'(1);
      lm0 = (cfg.left_margin > tsce_pkg::MARGIN_LIMIT) ? tsce_pkg::MARGIN_LIMIT
                                                        : cfg.left_margin;
      rm0 = (cfg.right_margin > tsce_pkg::MARGIN_LIMIT) ? tsce_pkg::MARGIN_LIMIT
                                                         : cfg.right_margin;
      rm1 = (rm0 < lm0) ? lm0 : rm0;
      // right margin at the limit follows the width
      rm2 = (rm1 == tsce_pkg::MARGIN_LIMIT) ? wm1_eff : rm1;
      lm_eff = (lm0 > wm1_eff) ? wm1_eff : lm0;
      rm_eff = (rm2 > wm1_eff) ? wm1_eff : rm2;
   end

   // cursor-relative values used during dispatch
   tsce_pkg::addr_type base_y, cur_addr, base_bottom, src_addr;
   tsce_pkg::count_type rows_below, scroll_cnt, char_cnt;
   logic at_bottom, wrap, raw_put;

   always_comb begin
      base_y      = row_base(line_ff);
      cur_addr    = base_y + tsce_pkg::addr_type'(col_ff);
      base_bottom = row_base(hm1_ff);
      rows_below  = tsce_pkg::count_type'(row_base(hm1_ff - line_ff));
      scroll_cnt  = tsce_pkg::count_type'(base_bottom);
      char_cnt    = tsce_pkg::count_type'(wm1_ff - col_ff);
      at_bottom   = (line_ff == hm1_ff);
      wrap        = (col_ff >= rm_ff);
      raw_put     = esc_ff || ((char_ff != tsce_pkg::CH_EOL) && disp_ff);
      if (up_ff) begin
         src_addr = row_step_ff
                  ? dst_ff + tsce_pkg::addr_type'(tsce_pkg::MAX_COLUMNS)
                  : dst_ff + tsce_pkg::addr_type'(1);
      end else begin
         src_addr = row_step_ff
                  ? dst_ff - tsce_pkg::addr_type'(tsce_pkg::MAX_COLUMNS)
                  : dst_ff - tsce_pkg::addr_type'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      char_in      = char_ff;
      rcol_in      = rcol_ff;
      rrow_in      = rrow_ff;
      wm1_in       = wm1_ff;
      hm1_in       = hm1_ff;
      lm_in        = lm_ff;
      rm_in        = rm_ff;
      disp_in      = disp_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      esc_in       = esc_ff;
      bell_in      = bell_ff;
      cell_in      = cell_ff;
      dst_in       = dst_ff;
      copy_cnt_in  = copy_cnt_ff;
      row_step_in  = row_step_ff;
      up_in        = up_ff;
      fill_addr_in = fill_addr_ff;
      fill_cnt_in  = fill_cnt_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_bell_in  = out_bell_ff;
      out_esc_in   = out_esc_ff;
      out_cell_in  = out_cell_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_bus.ready);
      mem_we       = 1'b0;
      mem_waddr    = fill_addr_ff;
      mem_wdata    = tsce_pkg::CH_BLANK;
      mem_raddr    = src_addr;

      case (state_ff)
         ST_INIT: begin
            mem_we       = 1'b1;
            fill_addr_in = fill_addr_ff + tsce_pkg::addr_type'(1);
            fill_cnt_in  = fill_cnt_ff - tsce_pkg::count_type'(1);
            if (fill_cnt_ff == tsce_pkg::count_type'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in   = req_bus.command;
               char_in  = req_bus.char_code;
               rcol_in  = req_bus.read_column;
               rrow_in  = req_bus.read_row;
               state_in = ST_START;
            end
         end
         ST_START: begin
            wm1_in   = wm1_eff;
            hm1_in   = hm1_eff;
            lm_in    = lm_eff;
            rm_in    = rm_eff;
            disp_in  = cfg.display_controls;
            col_in   = (col_ff > rm_eff) ? rm_eff : col_ff;
            line_in  = (line_ff > hm1_eff) ? hm1_eff : line_ff;
            bell_in  = 1'b0;
            cell_in  = '0;
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = ST_FINISH;
            case (cmd_ff)
               tsce_pkg::CMD_PUT: begin
                  if (raw_put || !((char_ff == tsce_pkg::CH_ESCAPE)
                                || (char_ff == tsce_pkg::CH_UP)
                                || (char_ff == tsce_pkg::CH_DOWN)
                                || (char_ff == tsce_pkg::CH_LEFT)
                                || (char_ff == tsce_pkg::CH_RIGHT)
                                || (char_ff == tsce_pkg::CH_CLEAR)
                                || (char_ff == tsce_pkg::CH_BACKSPACE)
                                || (char_ff == tsce_pkg::CH_EOL)
                                || (char_ff == tsce_pkg::CH_DEL_LINE)
                                || (char_ff == tsce_pkg::CH_INS_LINE)
                                || (char_ff == tsce_pkg::CH_BELL)
                                || (char_ff == tsce_pkg::CH_DEL_CHAR)
                                || (char_ff == tsce_pkg::CH_INS_CHAR))) begin
                     // printable or raw: store, advance, wrap, scroll
                     esc_in    = 1'b0;
                     mem_we    = 1'b1;
                     mem_waddr = cur_addr;
                     mem_wdata = char_ff;
                     if (wrap) begin
                        col_in = lm_ff;
                        if (at_bottom) begin
                           dst_in       = '0;
                           copy_cnt_in  = scroll_cnt;
                           row_step_in  = 1'b1;
                           up_in        = 1'b1;
                           fill_addr_in = base_bottom;
                           fill_cnt_in  = tsce_pkg::count_type'(tsce_pkg::MAX_COLUMNS);
                           state_in     = ST_COPY_RD;
                        end else begin
                           line_in = line_ff + tsce_pkg::row_type'(1);
                        end
                     end else begin
                        col_in = col_ff + tsce_pkg::col_type'(1);
                     end
                  end else begin
                     case (char_ff)
                        tsce_pkg::CH_ESCAPE: esc_in = 1'b1;
                        tsce_pkg::CH_UP: begin
                           line_in = (line_ff == '0) ? hm1_ff
                                   : line_ff - tsce_pkg::row_type'(1);
                        end
                        tsce_pkg::CH_DOWN: begin
                           line_in = at_bottom ? '0 : line_ff + tsce_pkg::row_type'(1);
                        end
                        tsce_pkg::CH_LEFT: begin
                           col_in = (col_ff == '0) ? wm1_ff
                                  : col_ff - tsce_pkg::col_type'(1);
                        end
                        tsce_pkg::CH_RIGHT: begin
                           col_in = (col_ff == wm1_ff) ? '0
                                  : col_ff + tsce_pkg::col_type'(1);
                        end
                        tsce_pkg::CH_CLEAR: begin
                           col_in       = lm_ff;
                           line_in      = '0;
                           fill_addr_in = '0;
                           fill_cnt_in  = tsce_pkg::count_type'(tsce_pkg::TOTAL_CELLS);
                           state_in     = ST_FILL;
                        end
                        tsce_pkg::CH_BACKSPACE: begin
                           mem_we    = 1'b1;
                           mem_waddr = cur_addr;
                           if (col_ff != '0) begin
                              col_in = col_ff - tsce_pkg::col_type'(1);
                           end
                        end
                        tsce_pkg::CH_EOL: begin
                           col_in = lm_ff;
                           if (at_bottom) begin
                              dst_in       = '0;
                              copy_cnt_in  = scroll_cnt;
                              row_step_in  = 1'b1;
                              up_in        = 1'b1;
                              fill_addr_in = base_bottom;
                              fill_cnt_in  = tsce_pkg::count_type'(tsce_pkg::MAX_COLUMNS);
                              state_in     = ST_COPY_RD;
                           end else begin
                              line_in = line_ff + tsce_pkg::row_type'(1);
                           end
                        end
                        tsce_pkg::CH_DEL_LINE: begin
                           col_in       = lm_ff;
                           dst_in       = base_y;
                           copy_cnt_in  = rows_below;
                           row_step_in  = 1'b1;
                           up_in        = 1'b1;
                           fill_addr_in = base_bottom;
                           fill_cnt_in  = tsce_pkg::count_type'(tsce_pkg::MAX_COLUMNS);
                           state_in     = ST_COPY_RD;
                        end
                        tsce_pkg::CH_INS_LINE: begin
                           // walk down from the last cell of the bottom row
                           dst_in       = base_bottom
                                        + tsce_pkg::addr_type'(tsce_pkg::MAX_COLUMNS - 1);
                           copy_cnt_in  = rows_below;
                           row_step_in  = 1'b1;
                           up_in        = 1'b0;
                           fill_addr_in = base_y;
                           fill_cnt_in  = tsce_pkg::count_type'(tsce_pkg::MAX_COLUMNS);
                           state_in     = ST_COPY_RD;
                        end
                        tsce_pkg::CH_BELL: bell_in = 1'b1;
                        tsce_pkg::CH_DEL_CHAR: begin
                           dst_in       = cur_addr;
                           copy_cnt_in  = char_cnt;
                           row_step_in  = 1'b0;
                           up_in        = 1'b1;
                           fill_addr_in = base_y + tsce_pkg::addr_type'(wm1_ff);
                           fill_cnt_in  = tsce_pkg::count_type'(1);
                           state_in     = ST_COPY_RD;
                        end
                        tsce_pkg::CH_INS_CHAR: begin
                           dst_in       = base_y + tsce_pkg::addr_type'(wm1_ff);
                           copy_cnt_in  = char_cnt;
                           row_step_in  = 1'b0;
                           up_in        = 1'b0;
                           fill_addr_in = cur_addr;
                           fill_cnt_in  = tsce_pkg::count_type'(1);
                           state_in     = ST_COPY_RD;
                        end
                        default: ;
                     endcase
                  end
               end
               tsce_pkg::CMD_READ: begin
                  if ((rcol_ff <= wm1_ff) && (rrow_ff <= hm1_ff)) begin
                     mem_raddr = row_base(rrow_ff) + tsce_pkg::addr_type'(rcol_ff);
                     state_in  = ST_READ_WAIT;
                  end
               end
               tsce_pkg::CMD_CLEAR: begin
                  esc_in       = 1'b0;
                  col_in       = lm_ff;
                  line_in      = '0;
                  fill_addr_in = '0;
                  fill_cnt_in  = tsce_pkg::count_type'(tsce_pkg::TOTAL_CELLS);
                  state_in     = ST_FILL;
               end
               default: ;
            endcase
         end
         ST_COPY_RD: begin
            if (copy_cnt_ff == '0) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_COPY_WR;
            end
         end
         ST_COPY_WR: begin
            mem_we      = 1'b1;
            mem_waddr   = dst_ff;
            mem_wdata   = rdata_ff;
            dst_in      = up_ff ? dst_ff + tsce_pkg::addr_type'(1)
                                : dst_ff - tsce_pkg::addr_type'(1);
            copy_cnt_in = copy_cnt_ff - tsce_pkg::count_type'(1);
            state_in    = ST_COPY_RD;
         end
         ST_FILL: begin
            mem_we       = 1'b1;
            fill_addr_in = fill_addr_ff + tsce_pkg::addr_type'(1);
            fill_cnt_in  = fill_cnt_ff - tsce_pkg::count_type'(1);
            if (fill_cnt_ff == tsce_pkg::count_type'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ_WAIT: begin
            cell_in  = rdata_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output word is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_col_in   = col_ff;
               out_row_in   = line_ff;
               out_bell_in  = bell_ff;
               out_esc_in   = esc_ff;
               out_cell_in  = cell_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      char_ff     <= char_in;
      rcol_ff     <= rcol_in;
      rrow_ff     <= rrow_in;
      wm1_ff      <= wm1_in;
      hm1_ff      <= hm1_in;
      lm_ff       <= lm_in;
      rm_ff       <= rm_in;
      disp_ff     <= disp_in;
      bell_ff     <= bell_in;
      cell_ff     <= cell_in;
      dst_ff      <= dst_in;
      copy_cnt_ff <= copy_cnt_in;
      row_step_ff <= row_step_in;
      up_ff       <= up_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_bell_ff <= out_bell_in;
      out_esc_ff  <= out_esc_in;
      out_cell_ff <= out_cell_in;
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= tsce_pkg::LEFT_RESET;
         line_ff      <= '0;
         esc_ff       <= 1'b0;
         fill_addr_ff <= '0;
         fill_cnt_ff  <= tsce_pkg::count_type'(tsce_pkg::TOTAL_CELLS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         esc_ff       <= esc_in;
         fill_addr_ff <= fill_addr_in;
         fill_cnt_ff  <= fill_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.cursor_column  = out_col_ff;
   assign rsp_bus.cursor_row     = out_row_ff;
   assign rsp_bus.bell           = out_bell_ff;
   assign rsp_bus.escape_pending = out_esc_ff;
   assign rsp_bus.cell_value     = out_cell_ff;

endmodule

@@ sim/screen_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_checker: response checker for the text screen character engine
// Keeps a shadow copy of the screen, cursor, escape flag and registers. It
// updates the copy for every request word taken by the engine, queues the
// response it should give, and compares each response word against it.
// ----------------------------------------------------------------------------
module screen_checker
   import tsce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tsce_req_if         req_mon,
   tsce_rsp_if         rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output int          pending_reports,
   output int          mismatch_count
);

   typedef struct packed {
      col_type  column;
      row_type  row;
      logic     bell;
      logic     escape;
      char_type cell_char;
   } screen_report_type;

   char_type          cells [MAX_ROWS][MAX_COLUMNS];
   int                cur_col;
   int                cur_row;
   bit                escape_armed;
   cfg_type           shadow_cfg;
   screen_report_type expected_reports [$];

   function automatic void blank_row(int r);
      int c;
      for (c = 0; c < MAX_COLUMNS; c++) cells[r][c] = CH_BLANK;
   endfunction

   function automatic void clear_screen(int lm);
      int r;
      for (r = 0; r < MAX_ROWS; r++) blank_row(r);
      cur_col = lm;
      cur_row = 0;
   endfunction

   // Pull rows below top up by one and blank the last row in use.
   function automatic void scroll_from(int top, int h);
      int r;
      int c;
      for (r = top; r + 1 < h; r++)
         for (c = 0; c < MAX_COLUMNS; c++) cells[r][c] = cells[r + 1][c];
      blank_row(h - 1);
   endfunction

   function automatic void advance_line(int h);
      cur_row++;
      if (cur_row >= h) begin
         scroll_from(0, h);
         cur_row = h - 1;
      end
   endfunction

   function automatic void print_char(char_type c, int lm, int rm, int h);
      cells[cur_row][cur_col] = c;
      cur_col++;
      if (cur_col > rm) begin
         cur_col = lm;
         advance_line(h);
      end
   endfunction

   function automatic screen_report_type edit_screen(cmd_type cmd, char_type code,
                                                     col_type rcol, row_type rrow);
      int                w, h, lm, rm, x, y, r, i;
      logic              bell_hit;
      char_type          cell_read;
      screen_report_type rep;
      w = shadow_cfg.screen_width;
      if (w < 1) w = 1;
      if (w > MAX_COLUMNS) w = MAX_COLUMNS;
      h = shadow_cfg.screen_height;
      if (h < 1) h = 1;
      if (h > MAX_ROWS) h = MAX_ROWS;
      lm = shadow_cfg.left_margin;
      rm = shadow_cfg.right_margin;
      if (lm > MARGIN_LIMIT) lm = MARGIN_LIMIT;
      if (rm > MARGIN_LIMIT) rm = MARGIN_LIMIT;
      if (rm < lm) rm = lm;
      // full right margin tracks the width
      if (rm == MARGIN_LIMIT) rm = w - 1;
      if (lm > w - 1) lm = w - 1;
      if (rm > w - 1) rm = w - 1;
      if (cur_col > rm) cur_col = rm;
      if (cur_row > h - 1) cur_row = h - 1;
      bell_hit = 1'b0;
      cell_read = '0;
      case (cmd)
         CMD_PUT: begin
            if (escape_armed) begin
               escape_armed = 1'b0;
               print_char(code, lm, rm, h);
            end else if (code != CH_EOL && shadow_cfg.display_controls) begin
               print_char(code, lm, rm, h);
            end else begin
               x = cur_col;
               y = cur_row;
               case (code)
                  CH_ESCAPE:    escape_armed = 1'b1;
                  CH_UP:        cur_row = (y != 0) ? y - 1 : h - 1;
                  CH_DOWN:      cur_row = (y + 1 >= h) ? 0 : y + 1;
                  CH_LEFT:      cur_col = (x != 0) ? x - 1 : w - 1;
                  CH_RIGHT:     cur_col = (x + 1 >= w) ? 0 : x + 1;
                  CH_CLEAR:     clear_screen(lm);
                  CH_BACKSPACE: begin
                     cells[y][x] = CH_BLANK;
                     if (x != 0) cur_col = x - 1;
                  end
                  CH_EOL: begin
                     cur_col = lm;
                     advance_line(h);
                  end
                  CH_DEL_LINE: begin
                     scroll_from(y, h);
                     cur_col = lm;
                  end
                  CH_INS_LINE: begin
                     for (r = h - 1; r > y; r--)
                        for (i = 0; i < MAX_COLUMNS; i++) cells[r][i] = cells[r - 1][i];
                     blank_row(y);
                  end
                  CH_BELL:      bell_hit = 1'b1;
                  CH_DEL_CHAR: begin
                     for (i = x; i < w - 1; i++) cells[y][i] = cells[y][i + 1];
                     cells[y][w - 1] = CH_BLANK;
                  end
                  CH_INS_CHAR: begin
                     for (i = w - 1; i > x; i--) cells[y][i] = cells[y][i - 1];
                     cells[y][x] = CH_BLANK;
                  end
                  default:      print_char(code, lm, rm, h);
               endcase
            end
         end
         CMD_READ: begin
            if (rcol < w && rrow < h) cell_read = cells[rrow][rcol];
         end
         CMD_CLEAR: begin
            clear_screen(lm);
            escape_armed = 1'b0;
         end
         default: ;
      endcase
      rep.column    = col_type'(cur_col);
      rep.row       = row_type'(cur_row);
      rep.bell      = bell_hit;
      rep.escape    = escape_armed;
      rep.cell_char = cell_read;
      return rep;
   endfunction

   always @(posedge clock) begin
      screen_report_type want;
      screen_report_type seen;
      if (reset) begin
         clear_screen(LEFT_RESET);
         escape_armed = 1'b0;
         shadow_cfg = '{WIDTH_RESET, HEIGHT_RESET, LEFT_RESET, RIGHT_RESET, 1'b0};
         expected_reports.delete();
         mismatch_count = 0;
         pending_reports <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_SCREEN_WIDTH:     shadow_cfg.screen_width     = pwdata[5:0];
               REG_SCREEN_HEIGHT:    shadow_cfg.screen_height    = pwdata[4:0];
               REG_LEFT_MARGIN:      shadow_cfg.left_margin      = pwdata[5:0];
               REG_RIGHT_MARGIN:     shadow_cfg.right_margin     = pwdata[5:0];
               REG_DISPLAY_CONTROLS: shadow_cfg.display_controls = pwdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_reports.push_back(edit_screen(req_mon.command, req_mon.char_code,
                                                   req_mon.read_column, req_mon.read_row));
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.column    = rsp_mon.cursor_column;
            seen.row       = rsp_mon.cursor_row;
            seen.bell      = rsp_mon.bell;
            seen.escape    = rsp_mon.escape_pending;
            seen.cell_char = rsp_mon.cell_value;
            if (expected_reports.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response word with none expected: col %0d row %0d",
                           $realtime, seen.column, seen.row);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (seen !== want) begin
                  if (mismatch_count < 10) begin
                     $write("%0t: response mismatch: col %0d/%0d row %0d/%0d bell %0b/%0b",
                            $realtime, want.column, seen.column, want.row, seen.row,
                            want.bell, seen.bell);
                     $display(" escape %0b/%0b cell %h/%h (expected/actual)",
                              want.escape, seen.escape, want.cell_char, seen.cell_char);
                  end
                  mismatch_count++;
               end
            end
         end
         pending_reports <= expected_reports.size();
      end
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the text screen character engine
// Drives a directed opening sequence and then random character, control,
// read and clear words under several register settings, with random gaps on
// both channels and two long response holds. The checker beside the engine
// predicts every response word.
// ----------------------------------------------------------------------------
module tb_top;
   import tsce_pkg::*;

   localparam int      CYCLE_LIMIT      = 5_000_000;
   localparam int      LONG_HOLD        = 300;
   localparam int      PHASES           = 8;
   localparam int      RANDOM_PER_PHASE = 50;
   localparam int      CONTROL_COUNT    = 15;
   localparam cmd_type CMD_UNUSED       = 2'd3;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int       send_idle_pct;
   int       recv_idle_pct;
   int       hold_requests;
   int       holds_served;
   int       cycle_count;
   int       pending_reports;
   int       mismatch_count;
   char_type control_codes [CONTROL_COUNT];

   tsce_req_if req_bus ();
   tsce_rsp_if rsp_bus ();

   text_screen_character_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   screen_checker mirror (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pending_reports (pending_reports),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Response side: random stalls, plus a long hold on request.
   initial begin
      int hold_count;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
            holds_served++;
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_register(reg_index_type index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(int w, int h, int lm, int rm, int dc);
      write_register(REG_SCREEN_WIDTH, w);
      write_register(REG_SCREEN_HEIGHT, h);
      write_register(REG_LEFT_MARGIN, lm);
      write_register(REG_RIGHT_MARGIN, rm);
      write_register(REG_DISPLAY_CONTROLS, dc);
   endtask

   task automatic send_word(cmd_type cmd, char_type code, col_type col, row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.char_code   <= code;
      req_bus.read_column <= col;
      req_bus.read_row    <= row;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_random_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 48)
         send_word(CMD_PUT, char_type'($urandom_range(8'h7C, 8'h20)),
                   col_type'($urandom_range(63)), row_type'($urandom_range(31)));
      else if (pick < 72)
         send_word(CMD_PUT, control_codes[$urandom_range(CONTROL_COUNT - 1)],
                   col_type'($urandom_range(63)), row_type'($urandom_range(31)));
      else if (pick < 86)
         send_word(CMD_READ, char_type'($urandom_range(255)),
                   col_type'($urandom_range(39)), row_type'($urandom_range(23)));
      else if (pick < 92)
         send_word(CMD_PUT, char_type'($urandom_range(255)),
                   col_type'($urandom_range(63)), row_type'($urandom_range(31)));
      else if (pick < 93)
         send_word(CMD_CLEAR, char_type'($urandom_range(255)),
                   col_type'($urandom_range(63)), row_type'($urandom_range(31)));
      else if (pick < 97)
         send_word(CMD_READ, char_type'($urandom_range(255)),
                   col_type'($urandom_range(63)), row_type'($urandom_range(31)));
      else
         send_word(CMD_UNUSED, char_type'($urandom_range(255)),
                   col_type'($urandom_range(63)), row_type'($urandom_range(31)));
   endtask

   initial begin
      int phase;
      int n;
      control_codes = '{CH_ESCAPE, CH_UP, CH_DOWN, CH_LEFT, CH_RIGHT, CH_BACKSPACE,
                        CH_EOL, CH_EOL, CH_EOL, CH_DEL_LINE, CH_INS_LINE, CH_BELL,
                        CH_DEL_CHAR, CH_INS_CHAR, CH_CLEAR};
      send_idle_pct = 7;
      recv_idle_pct = 74;
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.command     <= CMD_PUT;
      req_bus.char_code   <= CH_BLANK;
      req_bus.read_column <= '0;
      req_bus.read_row    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // opening sequence under the reset settings
      send_word(CMD_PUT, 8'h41, 6'd0, 5'd0);
      send_word(CMD_READ, 8'h00, 6'd2, 5'd0);
      send_word(CMD_PUT, 8'h00, 6'd63, 5'd31);
      send_word(CMD_PUT, CH_ESCAPE, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_EOL, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_BELL, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_UP, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_DOWN, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_LEFT, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_RIGHT, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_BACKSPACE, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_DEL_CHAR, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_INS_CHAR, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_INS_LINE, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_DEL_LINE, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_EOL, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_CLEAR, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_ESCAPE, 6'd0, 5'd0);
      send_word(CMD_CLEAR, 8'hFF, 6'd63, 5'd31);
      send_word(CMD_UNUSED, 8'hFF, 6'd63, 5'd31);
      send_word(CMD_READ, 8'hFF, 6'd63, 5'd31);
      send_word(CMD_READ, 8'h00, 6'd39, 5'd23);
      send_word(CMD_PUT, 8'h7F, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_ESCAPE, 6'd0, 5'd0);
      send_word(CMD_PUT, CH_ESCAPE, 6'd0, 5'd0);
      req_bus.valid <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         // registers change only once every response is in
         do @(posedge clock); while (pending_reports != 0);
         case (phase)
            0: apply_setting(40, 24, 2, 39, 0);
            1: apply_setting(40, 24, 0, 39, 0);
            2: apply_setting(1, 1, 0, 0, 0);
            3: apply_setting(12, 5, 3, 8, 1);
            4: apply_setting(63, 31, 50, 45, 0);
            5: apply_setting(0, 0, 63, 63, 1);
            6: apply_setting(20, 3, 25, 10, 0);
            default: apply_setting($urandom_range(63), $urandom_range(31),
                                   $urandom_range(63), $urandom_range(63),
                                   $urandom_range(1));
         endcase
         if (phase < 3) begin
            send_idle_pct = 7;
            recv_idle_pct = 74;
         end else if (phase < 6) begin
            send_idle_pct = 74;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == 10 && (phase == 1 || phase == 6)) hold_requests++;
            send_random_word();
         end
         req_bus.valid <= 1'b0;
      end

      do @(posedge clock); while (pending_reports != 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_reports == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
rtl/tsce_pkg.sv
rtl/tsce_if.sv
rtl/tsce_csr.sv
rtl/tsce_engine.sv
rtl/text_screen_character_engine.sv
sim/screen_checker.sv
sim/tb_top.sv
